// ----- hdl/bsst_pkg.sv -----
// package for the bounded set span tracker: widths, codes, state type and defaults
package bsst_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int VAL_W           = 32;
  localparam int CAP_W           = 11;
  localparam int CNT_OUT_W       = 11;
  localparam int STATUS_W        = 2;
  localparam int SPAN_W          = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET      = 11'd1024;
  localparam logic [VAL_W-1:0]  MIN_RESET      = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]  MAX_RESET      = 32'h8000_0000;
  localparam logic [SPAN_W-1:0] SHORTEST_RESET = 32'hFFFF_FFFF;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_VALID    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_RESULT
  } state_t;

endpackage

// ----- hdl/bsst_span_alu.sv -----
// shared absolute difference unit for two signed 32-bit values
module bsst_span_alu (
  input  logic signed [bsst_pkg::VAL_W-1:0]  a,
  input  logic signed [bsst_pkg::VAL_W-1:0]  b,
  output logic        [bsst_pkg::SPAN_W-1:0] diff
);

  logic signed [bsst_pkg::VAL_W:0] sub;
  logic signed [bsst_pkg::VAL_W:0] mag;

  // one wide subtract, then negate when negative
  always_comb begin
    sub  = {a[bsst_pkg::VAL_W-1], a} - {b[bsst_pkg::VAL_W-1], b};
    mag  = sub[bsst_pkg::VAL_W] ? -sub : sub;
    diff = mag[bsst_pkg::SPAN_W-1:0];
  end

endmodule

// ----- hdl/bounded_set_span_tracker.sv -----
// bounded set span tracker: store of signed numbers with running min, max and shortest span
// sequence: an added number passes scan (each held entry read from the store), drain, commit
//   and result before out_tvalid rises; with an empty set it skips scan and drain, a rejected
//   number goes straight to result, and result holds while an earlier result is not yet taken
// throughput: one transaction at a time, the next accepted in the cycle out_tvalid rises
// reset: synchronous active-low rst_n clears count, presets min, max, shortest, capacity 1024;
//   the value store is not cleared, only entries below the count are read
module bounded_set_span_tracker #(
  parameter int MAX_ENTRIES = bsst_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write: capacity
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // [1:0] status, [33:2] min_gap,
                                  // [65:34] longest_span, [76:66] stored_count, [79:77] zero
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int LW = (CW > bsst_pkg::CAP_W) ? CW : bsst_pkg::CAP_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_ENTRIES);

  bsst_pkg::state_t state_r, state_nxt;

  logic [bsst_pkg::CAP_W-1:0]    capacity_r;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 idx_r;
  logic signed [bsst_pkg::VAL_W-1:0] value_r;
  logic signed [bsst_pkg::VAL_W-1:0] min_r;
  logic signed [bsst_pkg::VAL_W-1:0] max_r;
  logic [bsst_pkg::SPAN_W-1:0]   shortest_r;
  logic                          reject_r;
  logic                          rd_vld_r;
  logic signed [bsst_pkg::VAL_W-1:0] rd_data_r;
  logic [bsst_pkg::VAL_W-1:0]    store_mem [MAX_ENTRIES];

  logic                          out_vld_r;
  logic [bsst_pkg::STATUS_W-1:0] out_status_r;
  logic [bsst_pkg::SPAN_W-1:0]   out_short_r;
  logic [bsst_pkg::SPAN_W-1:0]   out_long_r;
  logic [bsst_pkg::CNT_OUT_W-1:0] out_count_r;

  logic          in_acc;
  logic          out_free;
  logic          full;
  logic          last_idx;
  logic          do_scan;
  logic          do_commit;
  logic          do_result;
  logic [LW-1:0] limit;
  logic [LW-1:0] count_l;
  logic signed [bsst_pkg::VAL_W-1:0] alu_a;
  logic signed [bsst_pkg::VAL_W-1:0] alu_b;
  logic [bsst_pkg::SPAN_W-1:0]       alu_diff;

  // capacity limit, saturated at the store depth
  always_comb begin
    count_l  = LW'(count_r);
    limit    = (LW'(capacity_r) > MAX_L) ? MAX_L : LW'(capacity_r);
    full     = (count_l >= limit);
    last_idx = (idx_r == (count_r - CW'(1)));
    out_free = !out_vld_r || out_tready;
    in_acc   = in_tvalid && in_tready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsst_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (full) begin
            state_nxt = bsst_pkg::S_RESULT;
          end else if (count_r == '0) begin
            state_nxt = bsst_pkg::S_COMMIT;
          end else begin
            state_nxt = bsst_pkg::S_SCAN;
          end
        end
      end
      bsst_pkg::S_SCAN: begin
        if (last_idx) begin
          state_nxt = bsst_pkg::S_DRAIN;
        end
      end
      bsst_pkg::S_DRAIN:  state_nxt = bsst_pkg::S_COMMIT;
      bsst_pkg::S_COMMIT: state_nxt = bsst_pkg::S_RESULT;
      bsst_pkg::S_RESULT: begin
        if (out_free) begin
          state_nxt = bsst_pkg::S_IDLE;
        end
      end
      default: state_nxt = bsst_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    do_scan   = 1'b0;
    do_commit = 1'b0;
    do_result = 1'b0;
    case (state_r)
      bsst_pkg::S_IDLE:   in_tready = 1'b1;
      bsst_pkg::S_SCAN:   do_scan   = 1'b1;
      bsst_pkg::S_DRAIN:  do_scan   = 1'b0;
      bsst_pkg::S_COMMIT: do_commit = 1'b1;
      bsst_pkg::S_RESULT: do_result = out_free;
      default:            in_tready = 1'b0;
    endcase
  end

  // shared unit operands: stored entry against new value, or max against min
  always_comb begin
    if (state_r == bsst_pkg::S_RESULT) begin
      alu_a = max_r;
      alu_b = min_r;
    end else begin
      alu_a = rd_data_r;
      alu_b = value_r;
    end
  end

  bsst_span_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff)
  );

  // value store, one read and at most one write a cycle
  always_ff @(posedge clk) begin
    if (do_commit) begin
      store_mem[count_r[AW-1:0]] <= value_r;
    end
    rd_data_r <= store_mem[idx_r[AW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bsst_pkg::S_IDLE;
      capacity_r <= bsst_pkg::CAP_RESET;
      count_r    <= '0;
      idx_r      <= '0;
      min_r      <= bsst_pkg::MIN_RESET;
      max_r      <= bsst_pkg::MAX_RESET;
      shortest_r <= bsst_pkg::SHORTEST_RESET;
      reject_r   <= 1'b0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= do_scan;
      if (cfg_valid) begin
        capacity_r <= cfg_data;
      end
      if (in_acc) begin
        idx_r    <= '0;
        reject_r <= full;
      end else if (do_scan) begin
        idx_r <= idx_r + CW'(1);
      end
      // shortest span update from the registered store read
      if (rd_vld_r && (alu_diff < shortest_r)) begin
        shortest_r <= alu_diff;
      end
      if (do_commit) begin
        count_r <= count_r + CW'(1);
        if (value_r < min_r) begin
          min_r <= value_r;
        end
        if (value_r > max_r) begin
          max_r <= value_r;
        end
      end
      if (do_result) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      value_r <= in_tdata;
    end
    if (do_result) begin
      out_count_r <= count_l[bsst_pkg::CNT_OUT_W-1:0];
      if (count_r >= CW'(2)) begin
        out_status_r <= reject_r ? bsst_pkg::ST_REJECTED : bsst_pkg::ST_VALID;
        out_short_r  <= shortest_r;
        out_long_r   <= alu_diff;
      end else begin
        out_status_r <= reject_r ? bsst_pkg::ST_REJECTED : bsst_pkg::ST_TOO_FEW;
        out_short_r  <= '0;
        out_long_r   <= '0;
      end
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_count_r, out_long_r, out_short_r, out_status_r};

  // count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(count_r) <= MAX_L)
    else $error("count beyond store depth");

  // scan addresses stay below the count
  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsst_pkg::S_SCAN) |-> (idx_r < count_r))
    else $error("scan index past held entries");

  // commit adds exactly one entry
  a_commit_inc: assert property (@(posedge clk) disable iff (!rst_n)
    do_commit |=> (count_r == $past(count_r) + CW'(1)))
    else $error("commit did not add one entry");

  // an accepted transaction closes the input until its result is produced
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input reopened during work");

endmodule
